// File: sv/csrmv_pkg.sv
// shared types, constants and arithmetic helpers for the sparse matrix-vector block
package csrmv_pkg;

    // field widths
    localparam int IDX_W = 12;
    localparam int VAL_W = 32;
    localparam int ACC_W = 64;
    localparam int CMD_W = 2;
    localparam int FRAC_W = 24;

    // default vector memory depth
    localparam int VECTOR_DEPTH_DEF = 4096;

    // item kinds
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TERM  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_EMPTY = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

    // result kinds
    localparam logic KIND_ROW  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // one input item as it moves down the pipeline
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [IDX_W-1:0] col;
        logic [VAL_W-1:0] val;
        logic [IDX_W-1:0] dst;
        logic             last;
    } t_item;

    // item writes the vector memory
    function automatic logic wr_en(input t_item it);
        logic r;
        unique case (it.cmd)
            CMD_LOAD:  r = 1'b1;
            CMD_TERM:  r = it.last;
            CMD_EMPTY: r = 1'b1;
            default:   r = 1'b0;
        endcase
        return r;
    endfunction

    // entry that an item writes
    function automatic logic [IDX_W-1:0] wr_idx(input t_item it);
        return (it.cmd == CMD_LOAD) ? it.col : it.dst;
    endfunction

    // item produces a result transfer
    function automatic logic emits(input t_item it);
        logic r;
        unique case (it.cmd)
            CMD_LOAD:  r = 1'b0;
            CMD_TERM:  r = it.last;
            CMD_EMPTY: r = 1'b1;
            CMD_READ:  r = 1'b1;
            default:   r = 1'b0;
        endcase
        return r;
    endfunction

    // write value of a load or an empty row, known early
    function automatic logic [VAL_W-1:0] early_val(input t_item it);
        return (it.cmd == CMD_LOAD) ? it.val : '0;
    endfunction

    // 64-bit add, saturated to the signed range
    function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                                 input logic [ACC_W-1:0] b);
        logic [ACC_W-1:0] s;
        logic [ACC_W-1:0] r;
        s = a + b;
        r = s;
        if ((a[ACC_W-1] == b[ACC_W-1]) && (s[ACC_W-1] != a[ACC_W-1])) begin
            r = a[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        return r;
    endfunction

    // Q16.48 to Q8.24, round half up, saturate to 32 bits
    function automatic logic [VAL_W-1:0] round_q824(input logic [ACC_W-1:0] acc);
        logic [ACC_W-FRAC_W:0] q;
        logic [VAL_W-1:0]      r;
        q = {acc[ACC_W-1], acc[ACC_W-1:FRAC_W]}
            + {{(ACC_W-FRAC_W){1'b0}}, acc[FRAC_W-1]};
        if (q[ACC_W-FRAC_W:VAL_W-1] == '0 || q[ACC_W-FRAC_W:VAL_W-1] == '1) begin
            r = q[VAL_W-1:0];
        end else begin
            r = q[ACC_W-FRAC_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

// File: sv/csrmv_ram.sv
// generic single-port-write, single-port-read ram with registered read (read-first)
module csrmv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/csr_sparse_matrix_vector_multiply.sv
// top level: compressed-row sparse matrix times vector over an on-chip vector memory
//
// Takes one item per cycle while it is not stalled by a row-sum wait or a held
// output, and passes it through memory read, multiply, accumulate, round and write, and the output register.
// A nonzero term or a read whose column is the destination of a row still in the
// multiply or accumulate stage waits for that row sum; every
// other dependency through the vector memory is forwarded without a stall. The
// vector memory has no clearing pass: entries are valid once loaded or written
// by a row. The pipeline holds only when a result is ready and the output
// register is still waiting for its transfer.
module csr_sparse_matrix_vector_multiply #(
    parameter int VECTOR_DEPTH = csrmv_pkg::VECTOR_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,  // column_index[11:0], operand_value[43:12],
                                       // dest_index[55:44]
    input  logic [1:0]  s_axis_tuser,  // cmd[1:0]
    input  logic        s_axis_tlast,  // row_end
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // result_index[11:0], result_value[43:12],
                                       // zero fill[47:44]
    output logic [0:0]  m_axis_tuser   // result_kind[0]
);

    localparam int IDX_W = csrmv_pkg::IDX_W;
    localparam int VAL_W = csrmv_pkg::VAL_W;
    localparam int ACC_W = csrmv_pkg::ACC_W;
    localparam int AW    = $clog2(VECTOR_DEPTH);
    localparam int CW    = ((AW > IDX_W) ? AW : IDX_W) + 1;

    // index lies inside the memory
    function automatic logic in_range(input logic [IDX_W-1:0] idx);
        return CW'(idx) < CW'(VECTOR_DEPTH);
    endfunction

    function automatic logic [AW-1:0] to_addr(input logic [IDX_W-1:0] idx);
        logic [CW-1:0] ext;
        ext = CW'(idx);
        return ext[AW-1:0];
    endfunction

    // pipeline registers
    logic                   r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid;
    csrmv_pkg::t_item       r_s1_item, r_s2_item, r_s3_item, r_s4_item;
    logic [VAL_W-1:0]       r_s2_vec, r_s3_vec, r_s4_vec;
    logic [ACC_W-1:0]       r_s3_prod;
    logic [ACC_W-1:0]       r_s4_sum;
    logic [ACC_W-1:0]       r_acc;
    logic                   r_w_valid;
    logic [IDX_W-1:0]       r_w_idx;
    logic [VAL_W-1:0]       r_w_val;
    logic                   r_out_valid;
    logic                   r_out_kind;
    logic [IDX_W-1:0]       r_out_idx;
    logic [VAL_W-1:0]       r_out_val;

    csrmv_pkg::t_item       in_item;
    logic                   en;
    logic                   hazard;
    logic                   accept;
    logic                   s4_emit;
    logic [VAL_W-1:0]       s4_round;
    logic [VAL_W-1:0]       s4_wval;
    logic                   ram_we;
    logic [AW-1:0]          ram_raddr;
    logic [VAL_W-1:0]       ram_rdata;
    logic                   m2, m3, m4, mw;
    logic [VAL_W-1:0]       s1_vec;
    logic [ACC_W-1:0]       s3_acc_sum;
    logic [ACC_W-1:0]       s2_prod;

    // unpack the input transfer
    assign in_item.cmd  = s_axis_tuser;
    assign in_item.col  = s_axis_tdata[11:0];
    assign in_item.val  = s_axis_tdata[43:12];
    assign in_item.dst  = s_axis_tdata[55:44];
    assign in_item.last = s_axis_tlast;

    // freeze only when a result cannot move into the output register
    assign s4_emit = r_s4_valid && csrmv_pkg::emits(r_s4_item);
    assign en      = !(s4_emit && r_out_valid && !m_axis_tready);

    // row sum rounding and write value in the last stage
    assign s4_round = csrmv_pkg::round_q824(r_s4_sum);
    always_comb begin
        case (r_s4_item.cmd)
            csrmv_pkg::CMD_LOAD: s4_wval = r_s4_item.val;
            csrmv_pkg::CMD_TERM: s4_wval = s4_round;
            default:             s4_wval = '0;
        endcase
    end

    assign ram_we = en && r_s4_valid && csrmv_pkg::wr_en(r_s4_item)
                    && in_range(csrmv_pkg::wr_idx(r_s4_item));

    // forwarding matches for the column read in stage one
    assign m2 = r_s2_valid && csrmv_pkg::wr_en(r_s2_item)
                && (csrmv_pkg::wr_idx(r_s2_item) == r_s1_item.col);
    assign m3 = r_s3_valid && csrmv_pkg::wr_en(r_s3_item)
                && (csrmv_pkg::wr_idx(r_s3_item) == r_s1_item.col);
    assign m4 = r_s4_valid && csrmv_pkg::wr_en(r_s4_item)
                && (csrmv_pkg::wr_idx(r_s4_item) == r_s1_item.col);
    assign mw = r_w_valid && (r_w_idx == r_s1_item.col);

    // a row sum still in multiply or accumulate cannot be forwarded yet
    assign hazard = r_s1_valid && in_range(r_s1_item.col)
                    && (r_s1_item.cmd == csrmv_pkg::CMD_TERM
                        || r_s1_item.cmd == csrmv_pkg::CMD_READ)
                    && ((m2 && r_s2_item.cmd == csrmv_pkg::CMD_TERM)
                        || (m3 && r_s3_item.cmd == csrmv_pkg::CMD_TERM));

    // youngest older writer wins
    always_comb begin
        if (!in_range(r_s1_item.col)) begin
            s1_vec = '0;
        end else if (m2) begin
            s1_vec = csrmv_pkg::early_val(r_s2_item);
        end else if (m3) begin
            s1_vec = csrmv_pkg::early_val(r_s3_item);
        end else if (m4) begin
            s1_vec = s4_wval;
        end else if (mw) begin
            s1_vec = r_w_val;
        end else begin
            s1_vec = ram_rdata;
        end
    end

    // no transfer is taken while reset is held
    assign s_axis_tready = i_rst_n && en && !hazard;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // re-read the waiting column while stalled
    assign ram_raddr = hazard ? to_addr(r_s1_item.col) : to_addr(in_item.col);

    csrmv_ram #(
        .WIDTH (VAL_W),
        .DEPTH (VECTOR_DEPTH)
    ) u_vec_mem (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (to_addr(csrmv_pkg::wr_idx(r_s4_item))),
        .i_wdata (s4_wval),
        .i_re    (en),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // term product and accumulator update
    assign s2_prod    = ACC_W'($signed(r_s2_item.val) * $signed(r_s2_vec));
    assign s3_acc_sum = csrmv_pkg::sat_add(r_acc, r_s3_prod);

    // stage valids and accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_w_valid  <= 1'b0;
            r_acc      <= '0;
        end else if (en) begin
            if (!hazard) begin
                r_s1_valid <= accept;
            end
            r_s2_valid <= r_s1_valid && !hazard;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
            r_w_valid  <= ram_we;
            if (r_s3_valid) begin
                if (r_s3_item.cmd == csrmv_pkg::CMD_TERM) begin
                    r_acc <= r_s3_item.last ? '0 : s3_acc_sum;
                end else if (r_s3_item.cmd == csrmv_pkg::CMD_EMPTY) begin
                    r_acc <= '0;
                end
            end
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (en) begin
            if (!hazard) begin
                r_s1_item <= in_item;
            end
            r_s2_item <= r_s1_item;
            r_s2_vec  <= s1_vec;
            r_s3_item <= r_s2_item;
            r_s3_vec  <= r_s2_vec;
            r_s3_prod <= s2_prod;
            r_s4_item <= r_s3_item;
            r_s4_vec  <= r_s3_vec;
            r_s4_sum  <= s3_acc_sum;
            r_w_idx   <= csrmv_pkg::wr_idx(r_s4_item);
            r_w_val   <= s4_wval;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en && s4_emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && s4_emit) begin
            if (r_s4_item.cmd == csrmv_pkg::CMD_READ) begin
                r_out_kind <= csrmv_pkg::KIND_READ;
                r_out_idx  <= r_s4_item.col;
                r_out_val  <= r_s4_vec;
            end else begin
                r_out_kind <= csrmv_pkg::KIND_ROW;
                r_out_idx  <= r_s4_item.dst;
                r_out_val  <= s4_wval;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out_val, r_out_idx};
    assign m_axis_tuser  = r_out_kind;

    // accumulator is clear after a finished row
    a_acc_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_s3_valid && r_s3_item.cmd == csrmv_pkg::CMD_TERM && r_s3_item.last)
        |=> (r_acc == '0))
        else $error("accumulator not cleared after row end");

    // a stalled read leaves a bubble behind it
    a_hazard_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && hazard) |=> (!r_s2_valid && r_s1_valid))
        else $error("hazard stall did not insert a bubble");

    // a result that cannot leave stays in the last stage
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s4_emit && !en) |=> (r_s4_valid && $stable(r_s4_item)))
        else $error("pending result lost while output stalled");

endmodule

// File: dv/csr_sparse_matrix_vector_multiply_tb.sv
// self-checking testbench for the compressed-row sparse matrix-vector block
`timescale 1ns / 100ps

module csr_sparse_matrix_vector_multiply_tb;

    localparam int DEPTH          = csrmv_pkg::VECTOR_DEPTH_DEF;
    localparam int TOTAL_ITEMS    = 1825;
    localparam int QUIET_TAIL     = 200;
    localparam int SEGMENT_ITEMS  = 150;
    localparam int HOLD_AT        = 500;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_AT       = 1000;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 20;

    localparam longint Q824_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam longint Q824_MIN = -64'sh0000_0000_8000_0000;
    localparam longint ACC_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint ACC_MIN  = 64'sh8000_0000_0000_0000;

    // one expected or observed result transfer
    typedef struct {
        logic                        kind;
        logic [csrmv_pkg::IDX_W-1:0] index;
        logic [csrmv_pkg::VAL_W-1:0] value;
    } t_spmv_result;

    // predicts row sums and read-backs and holds them until the block sends them
    class spmv_scoreboard;
        logic [csrmv_pkg::VAL_W-1:0] vector_image [DEPTH];
        longint                      partial_sum;
        t_spmv_result                awaited_q [$];
        int                          errors;
        int                          kind_count [4];
        int                          rows_checked;
        int                          reads_checked;
        int                          saturated_rows;

        function new();
            partial_sum    = 0;
            errors         = 0;
            rows_checked   = 0;
            reads_checked  = 0;
            saturated_rows = 0;
            foreach (kind_count[i]) kind_count[i] = 0;
        endfunction

        // Q16.48 accumulate, clamped to the signed 64-bit range
        function longint add_clamped(input longint a, input longint b);
            longint s;
            s = a + b;
            if (a[63] == b[63] && s[63] != a[63]) s = a[63] ? ACC_MIN : ACC_MAX;
            return s;
        endfunction

        // drop 24 fraction bits rounding half up, then clamp to 32 bits
        function logic [csrmv_pkg::VAL_W-1:0] narrow_sum(input longint acc);
            longint q;
            q = (acc >>> csrmv_pkg::FRAC_W) + longint'(acc[csrmv_pkg::FRAC_W-1]);
            if (q > Q824_MAX) return 32'h7FFF_FFFF;
            if (q < Q824_MIN) return 32'h8000_0000;
            return q[csrmv_pkg::VAL_W-1:0];
        endfunction

        function int pending();
            return awaited_q.size();
        endfunction

        // update the vector image for one accepted item and queue its result
        function void note_input(input csrmv_pkg::t_item it);
            t_spmv_result r;
            longint       prod;
            kind_count[it.cmd]++;
            case (it.cmd)
                csrmv_pkg::CMD_LOAD: begin
                    vector_image[it.col] = it.val;
                end
                csrmv_pkg::CMD_TERM: begin
                    prod = longint'($signed(it.val))
                           * longint'($signed(vector_image[it.col]));
                    partial_sum = add_clamped(partial_sum, prod);
                    if (it.last) begin
                        r.kind  = csrmv_pkg::KIND_ROW;
                        r.index = it.dst;
                        r.value = narrow_sum(partial_sum);
                        partial_sum = 0;
                        vector_image[it.dst] = r.value;
                        if (r.value == 32'h7FFF_FFFF || r.value == 32'h8000_0000)
                            saturated_rows++;
                        awaited_q.push_back(r);
                    end
                end
                csrmv_pkg::CMD_EMPTY: begin
                    partial_sum = 0;
                    vector_image[it.dst] = '0;
                    r.kind  = csrmv_pkg::KIND_ROW;
                    r.index = it.dst;
                    r.value = '0;
                    awaited_q.push_back(r);
                end
                default: begin
                    r.kind  = csrmv_pkg::KIND_READ;
                    r.index = it.col;
                    r.value = vector_image[it.col];
                    awaited_q.push_back(r);
                end
            endcase
        endfunction

        // compare one result transfer with the oldest prediction
        function void check_result(input t_spmv_result got);
            t_spmv_result want;
            if (awaited_q.size() == 0) begin
                $error("unexpected result: kind %0d index %0d value %h",
                       got.kind, got.index, got.value);
                errors++;
                return;
            end
            want = awaited_q.pop_front();
            if (got.kind !== want.kind) begin
                $error("result_kind mismatch: expected %0d, actual %0d", want.kind, got.kind);
                errors++;
            end
            if (got.index !== want.index) begin
                $error("result_index mismatch: expected %0d, actual %0d",
                       want.index, got.index);
                errors++;
            end
            if (got.value !== want.value) begin
                $error("result_value mismatch: expected %h, actual %h", want.value, got.value);
                errors++;
            end
            if (want.kind == csrmv_pkg::KIND_ROW) rows_checked++;
            else reads_checked++;
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;   // column_index[11:0], operand_value[43:12], dest_index[55:44]
    logic [1:0]  s_axis_tuser;   // cmd[1:0]
    logic        s_axis_tlast;   // row_end
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // result_index[11:0], result_value[43:12], zero fill[47:44]
    logic [0:0]  m_axis_tuser;   // result_kind[0]

    spmv_scoreboard sb;
    int             sent_cnt;
    int             idle_pct;
    int             quiet_cycles;
    int             stall_left;
    bit             long_hold_done;
    bit             written_map [DEPTH];
    int             written_list [$];
    int             recent_writes [$];

    csr_sparse_matrix_vector_multiply dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // remember which entries hold data, and the latest ones for hazards
    function automatic void mark_written(input logic [csrmv_pkg::IDX_W-1:0] idx);
        if (!written_map[idx]) begin
            written_map[idx] = 1'b1;
            written_list.push_back(int'(idx));
        end
        recent_writes.push_back(int'(idx));
        if (recent_writes.size() > 6) recent_writes.delete(0);
    endfunction

    // entry that is safe to read, often one written a moment ago
    function automatic logic [csrmv_pkg::IDX_W-1:0] pick_written_col();
        if (recent_writes.size() > 0 && $urandom_range(0, 99) < 40)
            return 12'(recent_writes[$urandom_range(0, recent_writes.size() - 1)]);
        return 12'(written_list[$urandom_range(0, written_list.size() - 1)]);
    endfunction

    // index biased to a small region so writes and reads collide
    function automatic logic [csrmv_pkg::IDX_W-1:0] pick_index();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 50) return 12'($urandom_range(0, 31));
        if (sel < 60) return $urandom_range(0, 1) ? 12'hFFF : 12'h000;
        return 12'($urandom_range(0, DEPTH - 1));
    endfunction

    // Q8.24 value: full random, near unity, or a corner
    function automatic logic [csrmv_pkg::VAL_W-1:0] pick_value();
        int                          sel;
        logic [csrmv_pkg::VAL_W-1:0] v;
        sel = $urandom_range(0, 99);
        if (sel < 25) return $urandom;
        if (sel < 75) begin
            v = $urandom_range(0, 32'h03FF_FFFF);
            return v - 32'h0200_0000;
        end
        case ($urandom_range(0, 5))
            0: v = 32'h7FFF_FFFF;
            1: v = 32'h8000_0000;
            2: v = 32'h0000_0000;
            3: v = 32'hFFFF_FFFF;
            4: v = 32'h0080_0000;
            default: v = 32'h0100_0000;
        endcase
        return v;
    endfunction

    // offer one item, with an optional idle burst first, until it is taken
    task automatic send_item(input csrmv_pkg::t_item it);
        if ($urandom_range(0, 99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {it.dst, it.val, it.col};
        s_axis_tuser  <= it.cmd;
        s_axis_tlast  <= it.last;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_input(it);
        sent_cnt++;
    endtask

    task automatic issue(input logic [csrmv_pkg::CMD_W-1:0] cmd,
                         input logic [csrmv_pkg::IDX_W-1:0] col,
                         input logic [csrmv_pkg::VAL_W-1:0] val,
                         input logic [csrmv_pkg::IDX_W-1:0] dst,
                         input logic last);
        csrmv_pkg::t_item it;
        it.cmd  = cmd;
        it.col  = col;
        it.val  = val;
        it.dst  = dst;
        it.last = last;
        if (cmd == csrmv_pkg::CMD_LOAD) mark_written(col);
        else if ((cmd == csrmv_pkg::CMD_TERM && last) || cmd == csrmv_pkg::CMD_EMPTY)
            mark_written(dst);
        send_item(it);
    endtask

    // a row of terms over stored entries, closed with row_end when finish is set
    task automatic send_row(input int max_terms, input bit finish);
        int                          n;
        int                          k;
        logic [csrmv_pkg::IDX_W-1:0] dst;
        logic [csrmv_pkg::IDX_W-1:0] col;
        n   = $urandom_range(1, max_terms);
        dst = pick_index();
        for (k = 0; k < n; k++) begin
            col = pick_written_col();
            if (k == n - 1 && finish && $urandom_range(0, 9) == 0) dst = col;
            issue(csrmv_pkg::CMD_TERM, col, pick_value(),
                  (k == n - 1) ? dst : 12'($urandom), (k == n - 1) && finish);
        end
    endtask

    // result side: random stalls plus one long hold-off
    initial begin
        m_axis_tready <= 1'b0;
        stall_left     = 0;
        long_hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else if (!long_hold_done && sent_cnt >= HOLD_AT) begin
                long_hold_done = 1'b1;
                stall_left     = LONG_HOLD - 1;
                m_axis_tready <= 1'b0;
            end else if ($urandom_range(0, 99) < idle_pct) begin
                stall_left     = $urandom_range(1, 18) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // check every result transfer
    always @(posedge i_clk) begin
        t_spmv_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.kind  = m_axis_tuser[0];
            got.index = m_axis_tdata[11:0];
            got.value = m_axis_tdata[43:12];
            sb.check_result(got);
        end
    end

    // watchdog on cycles with no transfer on either side
    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    // stimulus
    initial begin
        int  next_segment;
        int  pick;
        bit  drained;
        sb             = new();
        sent_cnt       = 0;
        idle_pct       = 0;
        drained        = 1'b0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= csrmv_pkg::CMD_LOAD;
        s_axis_tlast  <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: corners, saturation, rounding, hazards, ignored row_end
        issue(csrmv_pkg::CMD_LOAD,  12'd0,    32'h8000_0000, 12'hFFF, 1'b1);
        issue(csrmv_pkg::CMD_LOAD,  12'hFFF,  32'h7FFF_FFFF, 12'd0,   1'b0);
        issue(csrmv_pkg::CMD_LOAD,  12'd1,    32'h0080_0000, 12'd0,   1'b0);
        issue(csrmv_pkg::CMD_LOAD,  12'd2,    32'hFFFF_FFFF, 12'd0,   1'b0);
        issue(csrmv_pkg::CMD_READ,  12'd0,    32'hFFFF_FFFF, 12'hFFF, 1'b1);
        issue(csrmv_pkg::CMD_READ,  12'hFFF,  32'h0,         12'd0,   1'b0);
        // min times min four times: positive clamp of the sum
        repeat (3) issue(csrmv_pkg::CMD_TERM, 12'd0, 32'h8000_0000, 12'd0, 1'b0);
        issue(csrmv_pkg::CMD_TERM,  12'd0,    32'h8000_0000, 12'd3,   1'b1);
        // max times min three times: negative clamp
        repeat (2) issue(csrmv_pkg::CMD_TERM, 12'hFFF, 32'h8000_0000, 12'd0, 1'b0);
        issue(csrmv_pkg::CMD_TERM,  12'hFFF,  32'h8000_0000, 12'hFFF, 1'b1);
        // exact half rounds up, minus half rounds to zero
        issue(csrmv_pkg::CMD_TERM,  12'd1,    32'h0000_0001, 12'd5,   1'b1);
        issue(csrmv_pkg::CMD_TERM,  12'd1,    32'hFFFF_FFFF, 12'd6,   1'b1);
        // term reads its own destination before the row result lands
        issue(csrmv_pkg::CMD_TERM,  12'd5,    32'h0100_0000, 12'd5,   1'b1);
        // unfinished row dropped by an empty row
        issue(csrmv_pkg::CMD_TERM,  12'd2,    32'h7FFF_FFFF, 12'd7,   1'b0);
        issue(csrmv_pkg::CMD_EMPTY, 12'hFFF,  32'hFFFF_FFFF, 12'd8,   1'b1);
        // a load in the middle of a row keeps the partial sum
        issue(csrmv_pkg::CMD_TERM,  12'd2,    32'h0000_0001, 12'd0,   1'b0);
        issue(csrmv_pkg::CMD_LOAD,  12'd9,    32'h1234_5678, 12'd0,   1'b0);
        issue(csrmv_pkg::CMD_TERM,  12'd9,    32'h0100_0000, 12'd10,  1'b1);
        issue(csrmv_pkg::CMD_READ,  12'd10,   32'h0,         12'd0,   1'b0);
        issue(csrmv_pkg::CMD_READ,  12'd8,    32'h0,         12'd0,   1'b0);
        issue(csrmv_pkg::CMD_READ,  12'd3,    32'h0,         12'd0,   1'b0);
        issue(csrmv_pkg::CMD_EMPTY, 12'd0,    32'h0,         12'hFFF, 1'b0);

        // random: mostly well-formed rows, plus loads, reads, empty rows and noise
        next_segment = sent_cnt;
        while (sent_cnt < TOTAL_ITEMS) begin
            if (sent_cnt >= next_segment) begin
                case ($urandom_range(0, 3))
                    0: idle_pct = 0;
                    1: idle_pct = 5;
                    2: idle_pct = 20;
                    default: idle_pct = 50;
                endcase
                next_segment += SEGMENT_ITEMS;
            end
            if (sent_cnt >= TOTAL_ITEMS - QUIET_TAIL) idle_pct = 0;
            // pause input until every result is back
            if (!drained && sent_cnt >= DRAIN_AT) begin
                drained        = 1'b1;
                s_axis_tvalid <= 1'b0;
                do @(posedge i_clk); while (sb.pending() != 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                send_row(6, 1'b1);
            end else if (pick < 65) begin
                issue(csrmv_pkg::CMD_LOAD, pick_index(), pick_value(), 12'($urandom),
                      1'($urandom));
            end else if (pick < 80) begin
                issue(csrmv_pkg::CMD_READ, pick_written_col(), $urandom, 12'($urandom),
                      1'($urandom));
            end else if (pick < 88) begin
                issue(csrmv_pkg::CMD_EMPTY, 12'($urandom), $urandom, pick_index(),
                      1'($urandom));
            end else if (pick < 94) begin
                send_row(12, 1'b1);
            end else begin
                // broken row: no row end, then an empty row or a row that carries on
                send_row(4, 1'b0);
                if ($urandom_range(0, 1))
                    issue(csrmv_pkg::CMD_EMPTY, 12'($urandom), $urandom, pick_index(),
                          1'($urandom));
            end
        end
        s_axis_tvalid <= 1'b0;

        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d input transfers: %0d loads, %0d terms, %0d empty rows, %0d reads",
                 sent_cnt, sb.kind_count[csrmv_pkg::CMD_LOAD],
                 sb.kind_count[csrmv_pkg::CMD_TERM],
                 sb.kind_count[csrmv_pkg::CMD_EMPTY], sb.kind_count[csrmv_pkg::CMD_READ]);
        $display("Checked %0d row results (%0d clamped) and %0d read-backs, %0d errors",
                 sb.rows_checked, sb.saturated_rows, sb.reads_checked, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
